// ----- rtl/pvd_pkg.sv -----
// Shared types and constants for the postings variable-length delta decoder.
package pvd_pkg;

    localparam int DocWidth   = 31;
    localparam int FreqWidth  = 32;
    localparam int ByteWidth  = 8;
    // four 7-bit groups are held between bytes; the fifth byte ends the integer
    localparam int AccWidth   = 28;
    localparam int IdxWidth   = 3;
    localparam int CfgIdxWidth = 1;

    localparam logic [CfgIdxWidth-1:0] CFG_DOC_TOTAL = 1'b0;
    localparam logic [CfgIdxWidth-1:0] CFG_WITH_FREQ = 1'b1;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_ZERO_COUNT,
        ERR_OVERLONG,
        ERR_DOC_OVERFLOW,
        ERR_EXTRA_BYTE,
        ERR_TRUNCATED
    } pvd_err_t;

    typedef struct packed {
        logic [AccWidth-1:0] vint;
        logic [IdxWidth-1:0] idx;
        logic                awaiting;
        logic [DocWidth-1:0] running;
        logic [DocWidth-1:0] done;
        logic                finished;
    } pvd_state_t;

    typedef struct packed {
        logic [DocWidth-1:0]  doc_id;
        logic [FreqWidth-1:0] frequency;
        logic                 doc_valid;
        logic                 last_in_term;
        pvd_err_t             error_code;
    } pvd_result_t;

endpackage

// ----- rtl/pvd_step.sv -----
// Per-byte decode: next term state and the optional result for one item.
module pvd_step
    import pvd_pkg::*;
(
    input  pvd_state_t           cur,
    input  logic [DocWidth-1:0]  doc_total,
    input  logic                 with_freq,
    input  logic [ByteWidth-1:0] data_byte,
    input  logic                 start_term,
    input  logic                 final_byte,
    output pvd_state_t           nxt,
    output logic                 emit,
    output pvd_result_t          res
);

    pvd_state_t           s;
    logic [AccWidth-1:0]  shifted;
    logic [FreqWidth-1:0] v;
    logic [FreqWidth-1:0] delta;
    logic [FreqWidth:0]   sum;
    logic                 doc_done;

    always_comb
    begin
        case (s.idx[1:0])
            2'd0:    shifted = {21'b0, data_byte[6:0]};
            2'd1:    shifted = {14'b0, data_byte[6:0], 7'b0};
            2'd2:    shifted = {7'b0, data_byte[6:0], 14'b0};
            2'd3:    shifted = {data_byte[6:0], 21'b0};
            default: shifted = '0;
        endcase
    end

    always_comb
    begin
        s = start_term ? '0 : cur;
        nxt = s;
        emit = 1'b0;
        res = '0;
        res.error_code = ERR_NONE;
        v = '0;
        delta = '0;
        sum = '0;
        doc_done = 1'b0;

        if (s.finished)
        begin
            emit = 1'b1;
            res.error_code = ERR_EXTRA_BYTE;
        end
        else if (doc_total == '0)
        begin
            nxt.finished = 1'b1;
            emit = 1'b1;
            res.error_code = ERR_ZERO_COUNT;
        end
        else if (s.idx[2] && (data_byte[7:4] != 4'b0))
        begin
            nxt.finished = 1'b1;
            emit = 1'b1;
            res.error_code = ERR_OVERLONG;
        end
        else if (!s.idx[2] && data_byte[7])
        begin
            // continuation: keep accumulating
            nxt.vint = s.vint | shifted;
            nxt.idx = s.idx + 3'd1;
            if (final_byte)
            begin
                nxt.finished = 1'b1;
                emit = 1'b1;
                res.error_code = ERR_TRUNCATED;
            end
        end
        else
        begin
            v = s.idx[2] ? {data_byte[3:0], s.vint} : {4'b0, s.vint | shifted};
            nxt.vint = '0;
            nxt.idx = '0;
            if (s.awaiting)
            begin
                nxt.awaiting = 1'b0;
                res.doc_id = s.running;
                res.frequency = v;
                doc_done = 1'b1;
            end
            else
            begin
                delta = with_freq ? {1'b0, v[FreqWidth-1:1]} : v;
                sum = {2'b0, s.running} + {1'b0, delta};
                if (sum[FreqWidth:DocWidth] != 2'b0)
                begin
                    nxt.finished = 1'b1;
                    emit = 1'b1;
                    res.error_code = ERR_DOC_OVERFLOW;
                end
                else
                begin
                    nxt.running = sum[DocWidth-1:0];
                    if (with_freq && !v[0])
                        nxt.awaiting = 1'b1;
                    else
                    begin
                        res.doc_id = sum[DocWidth-1:0];
                        res.frequency = FreqWidth'(1);
                        doc_done = 1'b1;
                    end
                end
            end

            if (doc_done)
            begin
                nxt.done = s.done + DocWidth'(1);
                res.doc_valid = 1'b1;
                emit = 1'b1;
                if (nxt.done == doc_total)
                begin
                    res.last_in_term = 1'b1;
                    nxt.finished = 1'b1;
                end
            end

            if (final_byte && !nxt.finished)
            begin
                nxt.finished = 1'b1;
                emit = 1'b1;
                res.error_code = ERR_TRUNCATED;
            end
        end
    end

endmodule

// ----- rtl/postings_vint_delta_decoder_unit.sv -----
// Postings decoder top level: input handshake, term state, result register.
//
// Usage: bytes of one term's postings stream enter on the in channel
// (data_byte, start_term, final_byte), one item per cycle when in_ready is
// high. Each byte gives zero or one result on the out channel: a completed
// document (doc_id, frequency, doc_valid, last_in_term) or an error code.
// Latency: a result appears in out_valid the cycle after the byte that
// caused it is accepted. Throughput: one byte per cycle while out_ready
// keeps the result register moving; the decode of one byte (shift-or into
// the accumulator, 33-bit add and compare against the doc id limit) sits
// between the term state registers and the result register.
// The configuration channel (cfg_index, cfg_data) is always ready; write
// the document count and with_freq between terms while the block is idle.
// Reset: term state clears, the document count goes to zero, with_freq to
// one, no result is pending. When the receiver stalls, the result register
// holds its item and in_ready drops until that item is taken; a byte that
// gives no result is still only taken when the result register can move.
module postings_vint_delta_decoder_unit
    import pvd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CfgIdxWidth-1:0] cfg_index,
    input  logic [DocWidth-1:0]    cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [ByteWidth-1:0]   data_byte,
    input  logic                   start_term,
    input  logic                   final_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [DocWidth-1:0]    doc_id,
    output logic [FreqWidth-1:0]   frequency,
    output logic                   doc_valid,
    output logic                   last_in_term,
    output logic [2:0]             error_code
);

    pvd_state_t          state_reg;
    pvd_state_t          state_next;
    pvd_result_t         res_reg;
    pvd_result_t         res_next;
    logic                res_emit;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [DocWidth-1:0] doc_total_reg;
    logic                with_freq_reg;
    logic                accept;

    pvd_step u_step (
        .cur        (state_reg),
        .doc_total  (doc_total_reg),
        .with_freq  (with_freq_reg),
        .data_byte  (data_byte),
        .start_term (start_term),
        .final_byte (final_byte),
        .nxt        (state_next),
        .emit       (res_emit),
        .res        (res_next)
    );

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (accept && res_emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
            doc_total_reg <= '0;
            with_freq_reg <= 1'b1;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
                state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DOC_TOTAL: doc_total_reg <= cfg_data;
                    CFG_WITH_FREQ: with_freq_reg <= cfg_data[0];
                    default:       doc_total_reg <= doc_total_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_emit)
            res_reg <= res_next;
    end

    assign out_valid    = out_valid_reg;
    assign doc_id       = res_reg.doc_id;
    assign frequency    = res_reg.frequency;
    assign doc_valid    = res_reg.doc_valid;
    assign last_in_term = res_reg.last_in_term;
    assign error_code   = res_reg.error_code;

endmodule

// ----- rtl/pvd_checker.sv -----
// Port-level checks for the postings decoder, bound to the top level.
module pvd_checker
    import pvd_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [DocWidth-1:0]    doc_id,
    input logic [FreqWidth-1:0]   frequency,
    input logic                   doc_valid,
    input logic                   last_in_term,
    input logic [2:0]             error_code
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(doc_id)
            && $stable(frequency) && $stable(doc_valid) && $stable(error_code)
            && $stable(last_in_term))
        else $error("result item changed while stalled");

    // no new item while the result register is blocked
    a_no_take_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input item taken while output stalled");

    // a result without a document is always an error report
    a_empty_is_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !doc_valid |-> error_code != ERR_NONE && doc_id == '0
            && frequency == '0 && !last_in_term)
        else $error("empty result item without error code");

    a_last_has_doc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_in_term |-> doc_valid && error_code == ERR_NONE)
        else $error("last document flag on an item without a document");

endmodule

bind postings_vint_delta_decoder_unit pvd_checker u_pvd_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the postings variable-length delta decoder.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pvd_pkg::*;

    typedef struct {
        logic [ByteWidth-1:0] value;
        bit                   start;
        bit                   fin;
        bit                   pause_first;  // hold off until all results are in
    } postings_byte_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CfgIdxWidth-1:0] cfg_index = CFG_DOC_TOTAL;
    logic [DocWidth-1:0]    cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [ByteWidth-1:0]   data_byte = '0;
    logic                   start_term = 1'b0;
    logic                   final_byte = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [DocWidth-1:0]    doc_id;
    logic [FreqWidth-1:0]   frequency;
    logic                   doc_valid;
    logic                   last_in_term;
    logic [2:0]             error_code;

    postings_vint_delta_decoder_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .start_term   (start_term),
        .final_byte   (final_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .doc_id       (doc_id),
        .frequency    (frequency),
        .doc_valid    (doc_valid),
        .last_in_term (last_in_term),
        .error_code   (error_code)
    );

    always #1 clk = ~clk;

    // decoder copy: configuration and term state
    logic [DocWidth-1:0] doc_limit = '0;
    logic                freq_coded = 1'b1;
    logic [31:0]         acc_bits;
    logic [IdxWidth-1:0] acc_groups;
    logic                freq_pending;
    logic [DocWidth-1:0] doc_sum;
    logic [DocWidth-1:0] docs_seen;
    logic                term_closed;

    postings_byte_t      pending_bytes[$];
    pvd_result_t         expected_docs[$];
    logic [7:0]          term_bytes[$];
    int                  bytes_queued = 0;
    int                  fail_count = 0;

    function automatic void clear_term();
        acc_bits     = '0;
        acc_groups   = '0;
        freq_pending = 1'b0;
        doc_sum      = '0;
        docs_seen    = '0;
        term_closed  = 1'b0;
    endfunction

    // returns 1 when the byte yields a result item
    function automatic bit decode_posting_byte(input logic [7:0] b, input bit start,
                                               input bit fin, output pvd_result_t r);
        logic [31:0] v;
        logic [31:0] delta;
        logic [32:0] sum;
        bit          emit;
        r = '0;
        r.error_code = ERR_NONE;
        emit = 1'b0;
        if (start)
            clear_term();
        if (term_closed)
        begin
            r.error_code = ERR_EXTRA_BYTE;
            return 1'b1;
        end
        if (doc_limit == '0)
        begin
            term_closed = 1'b1;
            r.error_code = ERR_ZERO_COUNT;
            return 1'b1;
        end
        if (acc_groups >= 4)
        begin
            if (b[7:4] != 4'h0)
            begin
                term_closed = 1'b1;
                r.error_code = ERR_OVERLONG;
                return 1'b1;
            end
            v = acc_bits | {b[3:0], 28'h0};
        end
        else
        begin
            acc_bits = acc_bits | (32'(b[6:0]) << (7 * acc_groups));
            if (b[7])
            begin
                acc_groups = acc_groups + 1'b1;
                if (fin)
                begin
                    term_closed = 1'b1;
                    r.error_code = ERR_TRUNCATED;
                    return 1'b1;
                end
                return 1'b0;
            end
            v = acc_bits;
        end
        acc_bits = '0;
        acc_groups = '0;

        if (freq_pending)
        begin
            freq_pending = 1'b0;
            r.doc_id = doc_sum;
            r.frequency = v;
            emit = 1'b1;
        end
        else
        begin
            delta = freq_coded ? (v >> 1) : v;
            sum = {2'b00, doc_sum} + {1'b0, delta};
            if (sum > 33'h0_7FFF_FFFF)
            begin
                term_closed = 1'b1;
                r.error_code = ERR_DOC_OVERFLOW;
                return 1'b1;
            end
            doc_sum = sum[DocWidth-1:0];
            if (freq_coded && !v[0])
                freq_pending = 1'b1;
            else
            begin
                r.doc_id = doc_sum;
                r.frequency = 32'd1;
                emit = 1'b1;
            end
        end

        if (emit)
        begin
            docs_seen = docs_seen + 1'b1;
            r.doc_valid = 1'b1;
            if (docs_seen == doc_limit)
            begin
                r.last_in_term = 1'b1;
                term_closed = 1'b1;
            end
        end
        if (fin && !term_closed)
        begin
            term_closed = 1'b1;
            r.error_code = ERR_TRUNCATED;
        end
        return emit || (r.error_code != ERR_NONE);
    endfunction

    // byte sender: bursts with gaps, holds the item until taken
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        postings_byte_t nxt;
        pvd_result_t    res;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            data_byte  <= '0;
            start_term <= 1'b0;
            final_byte <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (decode_posting_byte(data_byte, start_term, final_byte, res))
                    expected_docs.insert(expected_docs.size(), res);
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_bytes.size() != 0 &&
                         !(pending_bytes[0].pause_first && expected_docs.size() != 0))
                begin
                    nxt = pending_bytes.pop_front();
                    data_byte  <= nxt.value;
                    start_term <= nxt.start;
                    final_byte <= nxt.fin;
                    in_valid   <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            burst_left = $urandom_range(20, 60);
                            gap_left = 0;
                        end
                        else
                        begin
                            burst_left = $urandom_range(1, 12);
                            gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 25)
                                                                   : $urandom_range(0, 4);
                        end
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result receiver: stall style is redrawn whenever its mode counter runs out
    int stall_mode = 0;
    int mode_left = 100;
    int rx_cycle = 0;

    task automatic check_field(input string name, input longint unsigned exp_v,
                               input longint unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pvd_result_t exp_r;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_docs.size() == 0)
                begin
                    $error("result item with nothing expected: doc_id %0d error_code %0d",
                           doc_id, error_code);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_docs.pop_front();
                    check_field("doc_id", exp_r.doc_id, doc_id);
                    check_field("frequency", exp_r.frequency, frequency);
                    check_field("doc_valid", exp_r.doc_valid, doc_valid);
                    check_field("last_in_term", exp_r.last_in_term, last_in_term);
                    check_field("error_code", exp_r.error_code, error_code);
                end
            end
            rx_cycle++;
            mode_left--;
            if (mode_left <= 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(64, 256);
            end
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= (rx_cycle % 4 == 0);
                default: out_ready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    task automatic push_byte(input logic [7:0] b, input bit st, input bit fn,
                             input bit pz = 1'b0);
        postings_byte_t it;
        it.value = b;
        it.start = st;
        it.fin = fn;
        it.pause_first = pz;
        pending_bytes.insert(pending_bytes.size(), it);
        bytes_queued++;
    endtask

    task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [DocWidth-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_DOC_TOTAL)
            doc_limit = val;
        else
            freq_coded = val[0];
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        int quiet;
        quiet = 0;
        // counts consecutive quiet cycles: nothing queued, driven, held or awaited
        while (quiet < 4)
        begin
            @(posedge clk);
            if (pending_bytes.size() != 0 || in_valid || out_valid ||
                expected_docs.size() != 0)
                quiet = 0;
            else
                quiet++;
        end
    endtask

    // encodes value into term_bytes, optionally with redundant zero groups
    task automatic append_vint(input logic [31:0] value, input int pad);
        int n;
        int len;
        n = 1;
        while (n < 5 && (value >> (7 * n)) != 0)
            n++;
        len = (n + pad > 5) ? 5 : n + pad;
        for (int i = 0; i < len; i++)
        begin
            if (i < 4)
                term_bytes.insert(term_bytes.size(), {i < len - 1, value[7*i +: 7]});
            else
                term_bytes.insert(term_bytes.size(), {4'h0, value[31:28]});
        end
    endtask

    task automatic build_term(input int n_docs, input bit wf);
        logic [31:0] delta;
        logic [31:0] freq;
        int          pad;
        int          r;
        int          flaw;
        int          pos;
        bit          do_start;
        bit          mark_fin;
        term_bytes.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            // raw noise
            repeat ($urandom_range(1, 8))
                term_bytes.insert(term_bytes.size(), 8'($urandom));
        end
        else
        begin
            for (int d = 0; d < n_docs; d++)
            begin
                r = $urandom_range(0, 99);
                pad = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0;
                if (r < 60)
                    delta = $urandom_range(0, 100);
                else if (r < 96)
                    delta = $urandom_range(0, 1 << 21);
                else
                    delta = wf ? ($urandom >> 1) : $urandom;
                if (!wf)
                    append_vint(delta, pad);
                else if ($urandom_range(0, 1))
                    append_vint({delta[30:0], 1'b1}, pad);
                else
                begin
                    append_vint({delta[30:0], 1'b0}, pad);
                    freq = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 20) : $urandom;
                    append_vint(freq, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0);
                end
            end
        end
        if (term_bytes.size() == 0)
            term_bytes.insert(term_bytes.size(), 8'($urandom));

        do_start = 1'b1;
        mark_fin = 1'b1;
        flaw = $urandom_range(0, 11);
        case (flaw)
            0: if (term_bytes.size() > 1)
                   repeat ($urandom_range(1, term_bytes.size() - 1))
                       void'(term_bytes.pop_back());
            1: repeat ($urandom_range(1, 3))
                   term_bytes.insert(term_bytes.size(), 8'($urandom));
            2:
            begin
                pos = $urandom_range(0, term_bytes.size());
                for (int k = 0; k < 4; k++)
                    term_bytes.insert(pos + k, {1'b1, 7'($urandom)});
                term_bytes.insert(pos + 4, {4'($urandom_range(1, 15)), 4'($urandom)});
            end
            3: do_start = 1'b0;
            4: mark_fin = 1'b0;
            default: ;
        endcase

        foreach (term_bytes[i])
            push_byte(term_bytes[i], do_start && i == 0,
                      mark_fin && i == term_bytes.size() - 1,
                      $urandom_range(0, 99) == 0);
    endtask

    initial
    begin
        logic [DocWidth-1:0] count;
        bit                  wf;
        int                  n_docs;
        clear_term();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // registers at reset value: zero document count
        push_byte(8'hFF, 1'b1, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        wait_drained();

        // coded frequencies: implied one, widest explicit frequency, last doc, extra byte
        write_reg(CFG_DOC_TOTAL, 31'd3);
        write_reg(CFG_WITH_FREQ, 31'd1);
        push_byte(8'h03, 1'b1, 1'b0);
        push_byte(8'h04, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0, 1'b1);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h0F, 1'b0, 1'b0);
        push_byte(8'h01, 1'b0, 1'b1);
        push_byte(8'h00, 1'b0, 1'b0);
        wait_drained();

        // plain deltas: top doc id, then overflow; overlong; cut-short buffers
        write_reg(CFG_WITH_FREQ, 31'd0);
        push_byte(8'hFE, 1'b1, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h07, 1'b0, 1'b0);
        push_byte(8'h01, 1'b0, 1'b0);
        push_byte(8'h01, 1'b0, 1'b0);
        push_byte(8'h80, 1'b1, 1'b0);
        push_byte(8'h80, 1'b0, 1'b0);
        push_byte(8'h80, 1'b0, 1'b0);
        push_byte(8'h80, 1'b0, 1'b0);
        push_byte(8'h10, 1'b0, 1'b0);
        push_byte(8'h81, 1'b1, 1'b1);
        push_byte(8'h05, 1'b1, 1'b1);
        wait_drained();

        bytes_queued = 0;
        while (bytes_queued < 600)
        begin
            case ($urandom_range(0, 11))
                0: count = '0;
                1: count = 31'h7FFF_FFFF;
                default: count = 31'($urandom_range(1, 6));
            endcase
            wf = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 1))
            begin
                write_reg(CFG_DOC_TOTAL, count);
                write_reg(CFG_WITH_FREQ, {30'($urandom), wf});
            end
            else
            begin
                write_reg(CFG_WITH_FREQ, {30'($urandom), wf});
                write_reg(CFG_DOC_TOTAL, count);
            end
            repeat ($urandom_range(1, 4))
            begin
                if (count == '0)
                    n_docs = $urandom_range(0, 2);
                else if (count == 31'h7FFF_FFFF)
                    n_docs = $urandom_range(1, 6);
                else
                    n_docs = count;
                build_term(n_docs, wf);
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/pvd_pkg.sv
rtl/pvd_step.sv
rtl/postings_vint_delta_decoder_unit.sv
rtl/pvd_checker.sv
tb/tb_top.sv
